// ----- rtl/core/sal_pkg.sv -----
// Package for the shifting array list: field widths, word layout and codes.
// Used by shifting_array_list; depends on nothing else.
package sal_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int VALUE_W_DEF = 32;

    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 7;

    // Input word layout, lowest bit first: func, value, position, zero fill.
    localparam int IN_FUNC_LSB  = 0;
    localparam int IN_VALUE_LSB = IN_FUNC_LSB + FUNC_W;
    localparam int IN_POS_LSB   = IN_VALUE_LSB + DATA_W;
    localparam int IN_BITS      = IN_POS_LSB + POS_W;
    localparam int IN_W         = ((IN_BITS + 7) / 8) * 8;

    // Output word layout, lowest bit first: result_value, result_index, status, fill_length.
    localparam int OUT_BITS = DATA_W + INDEX_W + STATUS_W + LEN_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND  = 3'd0,
        FN_PREPEND = 3'd1,
        FN_DELETE  = 3'd2,
        FN_POP     = 3'd3,
        FN_READ    = 3'd4,
        FN_FIND    = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

endpackage

// ----- rtl/core/shifting_array_list.sv -----
// Shifting array list: ordered word list in one synchronous RAM with a fill count.
// Depends on sal_pkg for widths, word layout and operation/status codes.
//
// Every item passes S_IDLE, S_EXEC and S_FINISH in turn. Accepted pop, read and find,
// delete of a position below the last and prepend to a list neither empty nor full also
// pass S_WALK, where find reads one RAM entry per cycle through the read port; prepend
// then writes entry zero in S_TAIL. One item is in work at a time; the next word is taken
// only after a result loads, and a result held back by m_tready stalls the finish step.
// Reset clears the fill count and control state only.
module shifting_array_list #(
    parameter int DEPTH       = sal_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = sal_pkg::VALUE_W_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // func[2:0], value[34:3], position[40:35], zero fill above
    input  logic [sal_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // result_value[31:0], result_index[37:32], status[40:38], fill_length[47:41]
    output logic [sal_pkg::OUT_W-1:0] m_tdata
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMPW  = (CW > sal_pkg::POS_W) ? CW : sal_pkg::POS_W;
    localparam int DW    = sal_pkg::DATA_W;
    localparam int IDXW  = sal_pkg::INDEX_W;
    localparam int LENW  = sal_pkg::LEN_W;
    localparam int OUTW  = sal_pkg::OUT_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_WALK   = 5'b00100,
        S_TAIL   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    sal_pkg::func_t            func_reg, func_next;
    logic [VALUE_WIDTH-1:0]    word_reg, word_next;
    logic [sal_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [AW-1:0]             addr_reg, addr_next;
    logic [VALUE_WIDTH-1:0]    res_value_reg, res_value_next;
    logic [AW-1:0]             res_index_reg, res_index_next;
    sal_pkg::status_t          res_status_reg, res_status_next;
    logic                      out_valid_reg, out_valid_next;
    logic [OUTW-1:0]           out_data_reg, out_data_next;

    logic [VALUE_WIDTH-1:0]    store_mem [DEPTH];
    logic [VALUE_WIDTH-1:0]    rdata_reg;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [VALUE_WIDTH-1:0]    mem_wdata;
    logic [AW-1:0]             mem_raddr;

    logic                      is_full;
    logic                      is_empty;
    logic                      pos_bad;
    logic [AW-1:0]             last_addr;
    logic                      out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign pos_bad   = (CMPW'(pos_reg) >= CMPW'(count_reg));
    assign last_addr = AW'(count_reg - 1'b1);
    assign out_free  = !out_valid_reg || m_tready;

    // Single-port-write, single-port-read RAM with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= store_mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        word_next       = word_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        res_value_next  = res_value_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = rdata_reg;
        mem_raddr       = addr_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = sal_pkg::func_t'(
                        s_tdata[sal_pkg::IN_FUNC_LSB +: sal_pkg::FUNC_W]);
                    word_next  = VALUE_WIDTH'(s_tdata[sal_pkg::IN_VALUE_LSB +: DW]);
                    pos_next   = s_tdata[sal_pkg::IN_POS_LSB +: sal_pkg::POS_W];
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_value_next  = '0;
                res_index_next  = '0;
                res_status_next = sal_pkg::ST_OK;
                state_next      = S_FINISH;
                unique case (func_reg)
                    sal_pkg::FN_APPEND:
                    begin
                        if (is_full)
                        begin
                            res_status_next = sal_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(count_reg);
                            mem_wdata  = word_reg;
                            count_next = CW'(count_reg + 1'b1);
                        end
                    end
                    sal_pkg::FN_PREPEND:
                    begin
                        if (is_full)
                        begin
                            res_status_next = sal_pkg::ST_FULL;
                        end
                        else if (is_empty)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            mem_wdata  = word_reg;
                            count_next = CW'(count_reg + 1'b1);
                        end
                        else
                        begin
                            // shift up from the top entry down to entry zero
                            mem_raddr  = last_addr;
                            addr_next  = last_addr;
                            state_next = S_WALK;
                        end
                    end
                    sal_pkg::FN_DELETE:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = sal_pkg::ST_EMPTY;
                        end
                        else if (pos_bad)
                        begin
                            res_status_next = sal_pkg::ST_RANGE;
                        end
                        else if (AW'(pos_reg) == last_addr)
                        begin
                            count_next = CW'(count_reg - 1'b1);
                        end
                        else
                        begin
                            mem_raddr  = AW'(AW'(pos_reg) + 1'b1);
                            addr_next  = AW'(AW'(pos_reg) + 1'b1);
                            state_next = S_WALK;
                        end
                    end
                    sal_pkg::FN_POP:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = sal_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            mem_raddr  = last_addr;
                            count_next = CW'(count_reg - 1'b1);
                            state_next = S_WALK;
                        end
                    end
                    sal_pkg::FN_READ:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = sal_pkg::ST_EMPTY;
                        end
                        else if (pos_bad)
                        begin
                            res_status_next = sal_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_raddr  = AW'(pos_reg);
                            state_next = S_WALK;
                        end
                    end
                    sal_pkg::FN_FIND:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = sal_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            mem_raddr  = '0;
                            addr_next  = '0;
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                        // unused codes: leave the list alone and report ok
                    end
                endcase
            end

            S_WALK:
            begin
                unique case (func_reg)
                    sal_pkg::FN_PREPEND:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(addr_reg + 1'b1);
                        mem_wdata = rdata_reg;
                        if (addr_reg == '0)
                        begin
                            state_next = S_TAIL;
                        end
                        else
                        begin
                            mem_raddr = AW'(addr_reg - 1'b1);
                            addr_next = AW'(addr_reg - 1'b1);
                        end
                    end
                    sal_pkg::FN_DELETE:
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(addr_reg - 1'b1);
                        mem_wdata = rdata_reg;
                        if (addr_reg == last_addr)
                        begin
                            count_next = CW'(count_reg - 1'b1);
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            mem_raddr = AW'(addr_reg + 1'b1);
                            addr_next = AW'(addr_reg + 1'b1);
                        end
                    end
                    sal_pkg::FN_FIND:
                    begin
                        if (rdata_reg == word_reg)
                        begin
                            res_index_next = addr_reg;
                            state_next     = S_FINISH;
                        end
                        else if (addr_reg == last_addr)
                        begin
                            res_status_next = sal_pkg::ST_NOTFOUND;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            mem_raddr = AW'(addr_reg + 1'b1);
                            addr_next = AW'(addr_reg + 1'b1);
                        end
                    end
                    default:
                    begin
                        // pop and read: take the word fetched in the previous cycle
                        res_value_next = rdata_reg;
                        state_next     = S_FINISH;
                    end
                endcase
            end

            S_TAIL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = word_reg;
                count_next = CW'(count_reg + 1'b1);
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUTW'({LENW'(count_reg), res_status_reg,
                                            IDXW'(res_index_reg), DW'(res_value_reg)});
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        word_reg       <= word_next;
        pos_reg        <= pos_next;
        addr_reg       <= addr_next;
        res_value_reg  <= res_value_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

endmodule
